>>> src/fixed_point_quaternion_multiply_defines.svh
// ----------------------------------------------------------------------------
// fixed_point_quaternion_multiply_defines
// assertion macros shared by the quaternion multiplier rtl
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_QUATERNION_MULTIPLY_DEFINES_SVH
`define FIXED_POINT_QUATERNION_MULTIPLY_DEFINES_SVH
`ifndef ASSERT_OFF
// checked outside reset
`define FPQM_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("fpqm assertion failed");
// checked on every edge, reset included
`define FPQM_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("fpqm assertion failed");
`else
`define FPQM_ASSERT(label, clk, rst_n, prop)
`define FPQM_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

>>> src/fpqm_pkg.sv
// ----------------------------------------------------------------------------
// fpqm_pkg
// types, constants and rounding helper of the q20.12 quaternion multiplier
// ----------------------------------------------------------------------------
package fpqm_pkg;

	localparam int unsigned COMP_W    = 32;
	localparam int unsigned FRAC_BITS = 12;
	localparam int unsigned PROD_W    = COMP_W + FRAC_BITS;
	localparam int unsigned NUM_COMP  = 4;
	localparam int unsigned NUM_TERM  = NUM_COMP * NUM_COMP;

	// component order: scalar, i, j, k
	localparam int unsigned CW = 0;
	localparam int unsigned CX = 1;
	localparam int unsigned CY = 2;
	localparam int unsigned CZ = 3;

	localparam logic [PROD_W-1:0] ROUND_ADD = PROD_W'(12'h800);

	typedef logic signed [COMP_W-1:0] comp_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	typedef struct packed {
		comp_t a_w;
		comp_t a_x;
		comp_t a_y;
		comp_t a_z;
		comp_t b_w;
		comp_t b_x;
		comp_t b_y;
		comp_t b_z;
	} operands_t;

	typedef struct packed {
		comp_t out_w;
		comp_t out_x;
		comp_t out_y;
		comp_t out_z;
	} result_t;

	// round half up, drop fraction, keep low 32 bits
	function automatic comp_t round_term(prod_t p);
		logic [PROD_W-1:0] sum;
		sum = p + ROUND_ADD;
		return sum[PROD_W-1:FRAC_BITS];
	endfunction

endpackage

>>> src/fpqm_if.sv
// ----------------------------------------------------------------------------
// fpqm_if
// valid/ready request channels of the quaternion multiplier
// ----------------------------------------------------------------------------
interface fpqm_in_if;
	logic                  valid;
	logic                  ready;
	fpqm_pkg::operands_t   data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface fpqm_out_if;
	logic                  valid;
	logic                  ready;
	fpqm_pkg::result_t     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> src/fixed_point_quaternion_multiply.sv
// ----------------------------------------------------------------------------
// fixed_point_quaternion_multiply
// hamilton product of two q20.12 quaternions, four stage pipeline
// ----------------------------------------------------------------------------
// Takes one request per cycle while the output side is ready, and returns
// its product once stage four holds it. Stage one holds the sixteen
// 32x32 partial products (one multiplier each), stage two the rounded 32-bit
// terms, stage three the pairwise sums and stage four the result register.
// Each stage advances whenever it is empty or the next one moves, so a stall
// on the output backs up stage by stage and bubbles are squeezed out. Sums
// wrap modulo 2^32; rounding adds half an lsb and floors.
`include "fixed_point_quaternion_multiply_defines.svh"

module fixed_point_quaternion_multiply (
	input  logic              clk,
	input  logic              arst_n,
	fpqm_in_if.sink           operands,
	fpqm_out_if.source        product
);

	localparam int unsigned N = fpqm_pkg::NUM_COMP;
	localparam int unsigned T = fpqm_pkg::NUM_TERM;
	localparam int unsigned CW = fpqm_pkg::CW;
	localparam int unsigned CX = fpqm_pkg::CX;
	localparam int unsigned CY = fpqm_pkg::CY;
	localparam int unsigned CZ = fpqm_pkg::CZ;

	fpqm_pkg::comp_t a_v [N];
	fpqm_pkg::comp_t b_v [N];
	fpqm_pkg::prod_t mul [T];

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	fpqm_pkg::prod_t prod_s1 [T];
	fpqm_pkg::comp_t term_s2 [T];
	fpqm_pkg::comp_t h0_s3 [N];
	fpqm_pkg::comp_t h1_s3 [N];
	fpqm_pkg::result_t res_s4;

	assign a_v[CW] = operands.data.a_w;
	assign a_v[CX] = operands.data.a_x;
	assign a_v[CY] = operands.data.a_y;
	assign a_v[CZ] = operands.data.a_z;
	assign b_v[CW] = operands.data.b_w;
	assign b_v[CX] = operands.data.b_x;
	assign b_v[CY] = operands.data.b_y;
	assign b_v[CZ] = operands.data.b_z;

	// stall chain
	assign rdy_s4 = !valid_s4 || product.ready;
	assign rdy_s3 = !valid_s3 || rdy_s4;
	assign rdy_s2 = !valid_s2 || rdy_s3;
	assign rdy_s1 = !valid_s1 || rdy_s2;

	assign operands.ready = rdy_s1;
	assign product.valid  = valid_s4;
	assign product.data   = res_s4;

	// partial products, only the bits that survive rounding
	always_comb begin
		for (int i = 0; i < N; i++) begin
			for (int j = 0; j < N; j++) begin
				mul[N*i+j] = fpqm_pkg::prod_t'(a_v[i]) * fpqm_pkg::prod_t'(b_v[j]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy_s1) valid_s1 <= operands.valid;
			if (rdy_s2) valid_s2 <= valid_s1;
			if (rdy_s3) valid_s3 <= valid_s2;
			if (rdy_s4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			for (int k = 0; k < T; k++) begin
				prod_s1[k] <= mul[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			for (int k = 0; k < T; k++) begin
				term_s2[k] <= fpqm_pkg::round_term(prod_s1[k]);
			end
		end
	end

	// pairwise sums
	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			h0_s3[CW] <= term_s2[N*CW+CW] - term_s2[N*CX+CX];
			h1_s3[CW] <= term_s2[N*CY+CY] + term_s2[N*CZ+CZ];
			h0_s3[CX] <= term_s2[N*CW+CX] + term_s2[N*CX+CW];
			h1_s3[CX] <= term_s2[N*CY+CZ] - term_s2[N*CZ+CY];
			h0_s3[CY] <= term_s2[N*CW+CY] + term_s2[N*CY+CW];
			h1_s3[CY] <= term_s2[N*CZ+CX] - term_s2[N*CX+CZ];
			h0_s3[CZ] <= term_s2[N*CW+CZ] + term_s2[N*CZ+CW];
			h1_s3[CZ] <= term_s2[N*CX+CY] - term_s2[N*CY+CX];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			res_s4.out_w <= h0_s3[CW] - h1_s3[CW];
			res_s4.out_x <= h0_s3[CX] + h1_s3[CX];
			res_s4.out_y <= h0_s3[CY] + h1_s3[CY];
			res_s4.out_z <= h0_s3[CZ] + h1_s3[CZ];
		end
	end

	logic [3:0] vld_vec;
	logic       in_acc, out_acc;

	assign vld_vec = {valid_s1, valid_s2, valid_s3, valid_s4};
	assign in_acc  = operands.valid && operands.ready;
	assign out_acc = product.valid && product.ready;

	`FPQM_ASSERT(a_full_when_blocked, clk, arst_n, !operands.ready |-> (vld_vec == 4'b1111))
	`FPQM_ASSERT(a_occupancy, clk, arst_n, arst_n |=> ($countones(vld_vec) == $past($countones(vld_vec)) + int'($past(in_acc)) - int'($past(out_acc))))
	`FPQM_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |-> !product.valid)

endmodule
